[hdl/motion_state_classifier_defines.svh]
// Assertion macros for the checker of the motion state classifier.
// Depends on clk and arst_n being visible where a macro is used.
`ifndef MOTION_STATE_CLASSIFIER_DEFINES_SVH
`define MOTION_STATE_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define MSC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("motion_state_classifier: port property violated");

// Next-cycle implication, disabled while reset is asserted
`define MSC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("motion_state_classifier: port property violated");

`endif

[hdl/msc_pkg.sv]
// Shared types, fixed-point constants and the CORDIC angle table of the classifier.
// No dependencies.
`default_nettype none

package msc_pkg;

	// Datapath widths
	localparam int CordicW  = 34;
	localparam int SqrtW    = 61;
	localparam int RootW    = 31;
	localparam int AtanIdxW = 6;

	// Fixed-point constants
	localparam logic signed [CordicW-1:0] KinvQ30 = 34'sd652032874;
	localparam logic [63:0] PiQ60  = 64'h3243F6A8885A308D;
	localparam logic [63:0] FqFull = (PiQ60 + 64'd225000000) / 64'd450000000;
	localparam logic [32:0] Fq     = FqFull[32:0];
	localparam logic [SqrtW-1:0] OneQ60 = {1'b1, 60'b0};
	localparam logic signed [CordicW-1:0] TwoRCm = 34'sd1274200000;

	// Command from the sequencer to the CORDIC unit
	typedef struct packed {
		logic start;
		logic vector;
	} cordic_cmd_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_ACCEL_LIMIT    = 3'd0,
		REG_ALTITUDE_LIMIT = 3'd1,
		REG_SPEED_LIMIT    = 3'd2,
		REG_DISTANCE_LIMIT = 3'd3,
		REG_START_LAT      = 3'd4,
		REG_START_LON      = 3'd5,
		REG_START_ALT      = 3'd6
	} cfg_reg_t;

	// atan(2^-i) in Q2.30; exact powers of two from step 10 on, zero past step 30
	function automatic logic signed [CordicW-1:0] atan_entry(input logic [AtanIdxW-1:0] idx);
		logic signed [CordicW-1:0] val;
		unique case (idx)
			6'd0: val = 34'sd843314856;
			6'd1: val = 34'sd497837829;
			6'd2: val = 34'sd263043836;
			6'd3: val = 34'sd133525158;
			6'd4: val = 34'sd67021686;
			6'd5: val = 34'sd33543515;
			6'd6: val = 34'sd16775850;
			6'd7: val = 34'sd8388437;
			6'd8: val = 34'sd4194282;
			6'd9: val = 34'sd2097149;
			default: begin
				if (idx <= 6'd30)
					val = CordicW'(1) << (6'd30 - idx);
				else
					val = '0;
			end
		endcase
		return val;
	endfunction

endpackage

`default_nettype wire

[hdl/msc_cordic.sv]
// Iterative CORDIC unit, one micro-rotation per cycle, rotation or vectoring mode.
// Depends on msc_pkg.
`default_nettype none

module msc_cordic #(
	parameter int STEPS = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  msc_pkg::cordic_cmd_t                  cmd,
	input  logic signed [msc_pkg::CordicW-1:0]    x0,
	input  logic signed [msc_pkg::CordicW-1:0]    y0,
	input  logic signed [msc_pkg::CordicW-1:0]    z0,
	output logic signed [msc_pkg::CordicW-1:0]    x,
	output logic signed [msc_pkg::CordicW-1:0]    y,
	output logic signed [msc_pkg::CordicW-1:0]    z,
	output logic                                  done
);

	localparam int IdxW = $clog2(STEPS);
	localparam logic [IdxW-1:0] LastIdx = IdxW'(STEPS - 1);

	logic signed [msc_pkg::CordicW-1:0] x_q, y_q, z_q;
	logic signed [msc_pkg::CordicW-1:0] dx, dy, ang;
	logic [IdxW-1:0] i_q;
	logic busy_q, vec_q, done_q;
	logic pos;

	// Shifted terms, table angle and direction of this step
	always_comb begin
		dx  = y_q >>> i_q;
		dy  = x_q >>> i_q;
		ang = msc_pkg::atan_entry(msc_pkg::AtanIdxW'(i_q));
		pos = vec_q ? y_q[msc_pkg::CordicW-1] : ~z_q[msc_pkg::CordicW-1];
	end

	// Step counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			vec_q  <= 1'b0;
			i_q    <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (i_q == LastIdx) && !cmd.start;
			if (cmd.start) begin
				busy_q <= 1'b1;
				vec_q  <= cmd.vector;
				i_q    <= '0;
			end else if (busy_q) begin
				if (i_q == LastIdx)
					busy_q <= 1'b0;
				else
					i_q <= i_q + 1'b1;
			end
		end
	end

	// Load operands, then apply one micro-rotation a cycle
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			x_q <= x0;
			y_q <= y0;
			z_q <= z0;
		end else if (busy_q) begin
			if (pos) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - ang;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + ang;
			end
		end
	end

	assign x    = x_q;
	assign y    = y_q;
	assign z    = z_q;
	assign done = done_q;

endmodule

`default_nettype wire

[hdl/msc_sqrt.sv]
// Bit-serial integer square root, one result bit per cycle, floor of the root.
// Depends on msc_pkg.
`default_nettype none

module msc_sqrt (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [msc_pkg::SqrtW-1:0]         n,
	output logic [msc_pkg::RootW-1:0]         root,
	output logic                              done
);

	logic [msc_pkg::SqrtW-1:0] rem_q, res_q, bit_q, trial;
	logic busy_q, done_q;
	logic last;

	always_comb begin
		trial = res_q + bit_q;
		last  = (bit_q == msc_pkg::SqrtW'(1));
	end

	// Control: busy until the lowest bit pair is done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && last && !start;
			if (start)
				busy_q <= 1'b1;
			else if (busy_q && last)
				busy_q <= 1'b0;
		end
	end

	// Restoring square root, one trial subtract a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= n;
			res_q <= '0;
			bit_q <= msc_pkg::OneQ60;
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign root = res_q[msc_pkg::RootW-1:0];
	assign done = done_q;

endmodule

`default_nettype wire

[hdl/motion_state_classifier.sv]
// Each sample is worked through four rotation runs and one vectoring run of the shared
// CORDIC unit, two roots and nine multiplies, one after another. One sample is worked on
// at a time; in_ready and cfg_ready are high only while idle, and the next sample is taken
// while a finished result still waits on the output.
// Reset (arst_n low): idle, no result pending, all limits and previous position zero.
`default_nettype none

module motion_state_classifier #(
	parameter int CORDIC_STEPS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic signed [30:0] latitude,
	input  logic signed [31:0] longitude,
	input  logic signed [23:0] altitude,
	input  logic [15:0]        speed,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               flying
);

	localparam int W = msc_pkg::CordicW;
	localparam logic signed [W-1:0] HalfTurn    = 34'sd1800000000;
	localparam logic signed [W-1:0] FullTurn    = 34'sd3600000000;
	localparam logic signed [W-1:0] QuarterTurn = 34'sd900000000;
	localparam logic signed [67:0]  HalfQ30     = 68'sd536870912;
	localparam logic signed [67:0]  OneQ60Wide  = 68'sd1152921504606846976;

	typedef enum logic [12:0] {
		S_IDLE = 13'b0000000000001,
		S_MUL  = 13'b0000000000010,
		S_MULW = 13'b0000000000100,
		S_ANG  = 13'b0000000001000,
		S_ANGW = 13'b0000000010000,
		S_ROT  = 13'b0000000100000,
		S_SQX  = 13'b0000001000000,
		S_SQXW = 13'b0000010000000,
		S_SQY  = 13'b0000100000000,
		S_SQYW = 13'b0001000000000,
		S_VEC  = 13'b0010000000000,
		S_VECW = 13'b0100000000000,
		S_DONE = 13'b1000000000000
	} state_t;

	typedef enum logic [3:0] {
		OP_AX, OP_AY, OP_AZ, OP_LIM, OP_C1C2, OP_PS2, OP_S1S1, OP_QS2, OP_DIST
	} mul_op_t;

	typedef enum logic [1:0] {
		ANG_DLAT, ANG_DLON, ANG_COS1, ANG_COS2
	} ang_t;

	state_t  state_q;
	mul_op_t op_q;
	ang_t    k_q;
	logic    out_valid_q, flying_q, fly_q;

	// Limits and previous position
	logic [15:0]        accel_limit_q, speed_limit_q;
	logic [22:0]        altitude_limit_q;
	logic [23:0]        distance_limit_q;
	logic signed [30:0] prev_lat_q;
	logic signed [31:0] prev_lon_q;
	logic signed [23:0] prev_alt_q;

	// Sample under work
	logic signed [15:0] ax_q, ay_q, az_q;
	logic signed [30:0] lat_q;
	logic signed [31:0] lon_q;
	logic signed [23:0] alt_q;

	// Datapath registers
	logic signed [67:0] prod_q, acc_q;
	logic signed [W-1:0] mul_a, mul_b;
	logic signed [W-1:0] s1_q, s2_q, c1_q, c2_q, p_q, q_q, zc_q;
	logic [msc_pkg::SqrtW-1:0] a_q;
	logic [msc_pkg::RootW-1:0] rx_q;
	logic ang_neg_q, ang_half_q, cneg_q;

	// Angle preparation
	logic signed [W-1:0] dlat, dlon, lat_f, fold_u, u, umag, rmag, zang;
	logic fneg, half;
	logic [64:0] rsum;

	// Result shaping
	logic signed [67:0] rnd_sum, qsum;
	logic [31:0] dist_cm;
	logic signed [24:0] dalt;
	logic [24:0] absalt;
	logic [msc_pkg::SqrtW-1:0] a_clamped;

	// Shared unit handshakes
	msc_pkg::cordic_cmd_t cmd;
	logic signed [W-1:0] cx0, cy0, cz0, cx, cy, cz;
	logic cdone;
	logic sq_start, sq_done;
	logic [msc_pkg::SqrtW-1:0] sq_n;
	logic [msc_pkg::RootW-1:0] sq_root;
	logic out_load;

	function automatic logic signed [33:0] wrap_turn(input logic signed [33:0] d);
		logic signed [33:0] r;
		if (d > HalfTurn)
			r = d - FullTurn;
		else if (d < -HalfTurn)
			r = d + FullTurn;
		else
			r = d;
		return r;
	endfunction

	// Differences, latitude fold and the angle magnitude for the multiplier
	always_comb begin
		dlat  = wrap_turn(W'(lat_q) - W'(prev_lat_q));
		dlon  = wrap_turn(W'(lon_q) - W'(prev_lon_q));
		lat_f = (k_q == ANG_COS1) ? W'(prev_lat_q) : W'(lat_q);
		if (lat_f > QuarterTurn) begin
			fold_u = HalfTurn - lat_f;
			fneg   = 1'b1;
		end else if (lat_f < -QuarterTurn) begin
			fold_u = -HalfTurn - lat_f;
			fneg   = 1'b1;
		end else begin
			fold_u = lat_f;
			fneg   = 1'b0;
		end
		unique case (k_q)
			ANG_DLAT: begin
				u    = dlat;
				half = 1'b1;
			end
			ANG_DLON: begin
				u    = dlon;
				half = 1'b1;
			end
			default: begin
				u    = fold_u;
				half = 1'b0;
			end
		endcase
		umag = u[W-1] ? -u : u;
	end

	// Round the scaled magnitude back to Q2.30 radians and restore the sign
	always_comb begin
		rsum = {1'b0, prod_q[63:0]} + (ang_half_q ? (65'd1 << 32) : (65'd1 << 31));
		rmag = ang_half_q ? W'(rsum[64:33]) : W'(rsum[64:32]);
		zang = ang_neg_q ? -rmag : rmag;
	end

	// Operand select of the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == S_ANG) begin
			mul_a = {3'b000, umag[30:0]};
			mul_b = {1'b0, msc_pkg::Fq};
		end else begin
			unique case (op_q)
				OP_AX: begin
					mul_a = W'(ax_q);
					mul_b = W'(ax_q);
				end
				OP_AY: begin
					mul_a = W'(ay_q);
					mul_b = W'(ay_q);
				end
				OP_AZ: begin
					mul_a = W'(az_q);
					mul_b = W'(az_q);
				end
				OP_LIM: begin
					mul_a = {18'b0, accel_limit_q};
					mul_b = {18'b0, accel_limit_q};
				end
				OP_C1C2: begin
					mul_a = c1_q;
					mul_b = c2_q;
				end
				OP_PS2: begin
					mul_a = p_q;
					mul_b = s2_q;
				end
				OP_S1S1: begin
					mul_a = s1_q;
					mul_b = s1_q;
				end
				OP_QS2: begin
					mul_a = q_q;
					mul_b = s2_q;
				end
				OP_DIST: begin
					mul_a = zc_q;
					mul_b = msc_pkg::TwoRCm;
				end
				default: begin
					mul_a = '0;
					mul_b = '0;
				end
			endcase
		end
	end

	// Rounding, clamping and the quick tests
	always_comb begin
		rnd_sum = prod_q + HalfQ30;
		dist_cm = rnd_sum[61:30];
		qsum    = acc_q + prod_q;
		if (qsum[67])
			a_clamped = '0;
		else if (qsum > OneQ60Wide)
			a_clamped = msc_pkg::OneQ60;
		else
			a_clamped = qsum[60:0];
		dalt   = 25'(altitude) - 25'(prev_alt_q);
		absalt = dalt[24] ? 25'(-dalt) : 25'(dalt);
	end

	// Shared unit commands
	always_comb begin
		cmd.start  = (state_q == S_ANGW) || (state_q == S_VEC);
		cmd.vector = (state_q == S_VEC);
		cx0 = cmd.vector ? W'({3'b000, rx_q}) : msc_pkg::KinvQ30;
		cy0 = cmd.vector ? W'({3'b000, sq_root}) : '0;
		cz0 = cmd.vector ? '0 : zang;
		sq_start = (state_q == S_SQX) || (state_q == S_SQY);
		sq_n     = (state_q == S_SQX) ? (msc_pkg::OneQ60 - a_q) : a_q;
		out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);
	end

	msc_cordic #(
		.STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.x0    (cx0),
		.y0    (cy0),
		.z0    (cz0),
		.x     (cx),
		.y     (cy),
		.z     (cz),
		.done  (cdone)
	);

	msc_sqrt u_sqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (sq_start),
		.n     (sq_n),
		.root  (sq_root),
		.done  (sq_done)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_AX;
			k_q         <= ANG_DLAT;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q    <= OP_AX;
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_MULW;
				S_MULW: begin
					unique case (op_q)
						OP_AX: begin
							op_q    <= OP_AY;
							state_q <= S_MUL;
						end
						OP_AY: begin
							op_q    <= OP_AZ;
							state_q <= S_MUL;
						end
						OP_AZ: begin
							op_q    <= OP_LIM;
							state_q <= S_MUL;
						end
						OP_LIM: begin
							k_q     <= ANG_DLAT;
							state_q <= S_ANG;
						end
						OP_C1C2: begin
							op_q    <= OP_PS2;
							state_q <= S_MUL;
						end
						OP_PS2: begin
							op_q    <= OP_S1S1;
							state_q <= S_MUL;
						end
						OP_S1S1: begin
							op_q    <= OP_QS2;
							state_q <= S_MUL;
						end
						OP_QS2: state_q <= S_SQX;
						OP_DIST: state_q <= S_DONE;
						default: state_q <= S_IDLE;
					endcase
				end
				S_ANG:  state_q <= S_ANGW;
				S_ANGW: state_q <= S_ROT;
				S_ROT: begin
					if (cdone) begin
						unique case (k_q)
							ANG_DLAT: begin
								k_q     <= ANG_DLON;
								state_q <= S_ANG;
							end
							ANG_DLON: begin
								k_q     <= ANG_COS1;
								state_q <= S_ANG;
							end
							ANG_COS1: begin
								k_q     <= ANG_COS2;
								state_q <= S_ANG;
							end
							default: begin
								op_q    <= OP_C1C2;
								state_q <= S_MUL;
							end
						endcase
					end
				end
				S_SQX: state_q <= S_SQXW;
				S_SQXW: begin
					if (sq_done)
						state_q <= S_SQY;
				end
				S_SQY: state_q <= S_SQYW;
				S_SQYW: begin
					if (sq_done)
						state_q <= S_VEC;
				end
				S_VEC: state_q <= S_VECW;
				S_VECW: begin
					if (cdone) begin
						op_q    <= OP_DIST;
						state_q <= S_MUL;
					end
				end
				S_DONE: begin
					if (out_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Configuration registers and previous position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_limit_q    <= '0;
			altitude_limit_q <= '0;
			speed_limit_q    <= '0;
			distance_limit_q <= '0;
			prev_lat_q       <= '0;
			prev_lon_q       <= '0;
			prev_alt_q       <= '0;
		end else if (out_load) begin
			prev_lat_q <= lat_q;
			prev_lon_q <= lon_q;
			prev_alt_q <= alt_q;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				msc_pkg::REG_ACCEL_LIMIT:    accel_limit_q    <= cfg_data[15:0];
				msc_pkg::REG_ALTITUDE_LIMIT: altitude_limit_q <= cfg_data[22:0];
				msc_pkg::REG_SPEED_LIMIT:    speed_limit_q    <= cfg_data[15:0];
				msc_pkg::REG_DISTANCE_LIMIT: distance_limit_q <= cfg_data[23:0];
				msc_pkg::REG_START_LAT:      prev_lat_q       <= cfg_data[30:0];
				msc_pkg::REG_START_LON:      prev_lon_q       <= cfg_data[31:0];
				msc_pkg::REG_START_ALT:      prev_alt_q       <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		prod_q <= 68'(mul_a) * 68'(mul_b);
		if (out_load)
			flying_q <= fly_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ax_q  <= accel_x;
					ay_q  <= accel_y;
					az_q  <= accel_z;
					lat_q <= latitude;
					lon_q <= longitude;
					alt_q <= altitude;
					fly_q <= (absalt > {2'b00, altitude_limit_q}) || (speed > speed_limit_q);
				end
			end
			S_MULW: begin
				unique case (op_q)
					OP_AX:   acc_q <= prod_q;
					OP_AY:   acc_q <= qsum;
					OP_AZ:   acc_q <= qsum;
					OP_LIM: begin
						if (acc_q > prod_q)
							fly_q <= 1'b1;
					end
					OP_C1C2: p_q <= rnd_sum[63:30];
					OP_PS2:  q_q <= rnd_sum[63:30];
					OP_S1S1: acc_q <= prod_q;
					OP_QS2:  a_q <= a_clamped;
					OP_DIST: begin
						if (dist_cm > {8'b0, distance_limit_q})
							fly_q <= 1'b1;
					end
					default: ;
				endcase
			end
			S_ANG: begin
				ang_neg_q  <= u[W-1];
				ang_half_q <= half;
				cneg_q     <= fneg;
			end
			S_ROT: begin
				if (cdone) begin
					unique case (k_q)
						ANG_DLAT: s1_q <= cy;
						ANG_DLON: s2_q <= cy;
						ANG_COS1: c1_q <= cneg_q ? -cx : cx;
						default:  c2_q <= cneg_q ? -cx : cx;
					endcase
				end
			end
			S_SQXW: begin
				if (sq_done)
					rx_q <= sq_root;
			end
			S_VECW: begin
				if (cdone)
					zc_q <= cz[W-1] ? '0 : cz;
			end
			default: ;
		endcase
	end

	// Take register writes only while no sample is under work
	assign cfg_ready = (state_q == S_IDLE);
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign flying    = flying_q;

endmodule

`default_nettype wire

[hdl/msc_checker.sv]
// Port-level checker for the motion state classifier, bound to the top level.
// Depends on motion_state_classifier_defines.svh.
`default_nettype none
`include "motion_state_classifier_defines.svh"

module msc_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic flying
);

	// A sample keeps the block busy for at least the following cycle
	`MSC_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

	// A fresh result only appears while a sample is being worked on
	`MSC_ASSERT_IMP(a_result_from_busy, $rose(out_valid), !$past(in_ready))

	// Hold a stalled result beat
	`MSC_ASSERT_NXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(flying))

endmodule

bind motion_state_classifier msc_checker u_msc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.flying   (flying)
);

`default_nettype wire
